FILE: src/shd64_pkg.sv
// Shared types, constants and round helper functions for the Shadow-64 encryption pipeline.
// Used by shd64_round and shadow64_block_encrypt; it depends on nothing else.
package shd64_pkg;

  localparam int ROUNDS = 32;

  localparam logic [31:0] KEY_TAP_MASK = 32'h0002_0000;
  localparam logic [31:0] KEY_FEEDBACK = 32'h0000_0087;

  typedef logic [15:0] half_t;
  typedef logic [31:0] kword_t;

  // Cipher state between rounds: the four data halves and the four key words.
  typedef struct packed {
    half_t             l0;
    half_t             l1;
    half_t             r0;
    half_t             r1;
    logic [3:0][31:0]  kw;
  } blk_state_t;

  function automatic half_t mix(input half_t x);
    half_t rot1;
    half_t rot2;
    half_t rot7;
    rot1 = {x[14:0], x[15]};
    rot2 = {x[13:0], x[15:14]};
    rot7 = {x[8:0], x[15:9]};
    return (rot1 & rot7) ^ rot2;
  endfunction

  function automatic kword_t next_key_word(input kword_t w);
    kword_t t;
    t = {w[30:0], w[31]};
    if ((w & KEY_TAP_MASK) != '0) begin
      t = t ^ KEY_FEEDBACK;
    end
    return {t[15:0], t[31:16]};
  endfunction

endpackage

FILE: src/shd64_round.sv
// One round of Shadow-64: key word update followed by the two-layer data mix.
// Depends on shd64_pkg for the state type and the helper functions.
module shd64_round import shd64_pkg::*; (
  input  blk_state_t st_i,
  output blk_state_t st_o
);

  logic [3:0][31:0] kw_next;
  half_t            s0;
  half_t            s1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kw_next[i] = next_key_word(st_i.kw[i]);
    end
  end

  // The upper half of each updated key word is that round's subkey.
  assign s0 = mix(st_i.l0) ^ st_i.l1 ^ kw_next[0][31:16];
  assign s1 = mix(st_i.r0) ^ st_i.r1 ^ kw_next[1][31:16];

  assign st_o.l1 = mix(s0) ^ st_i.l0 ^ kw_next[2][31:16];
  assign st_o.r1 = mix(s1) ^ st_i.r0 ^ kw_next[3][31:16];
  assign st_o.l0 = s1;
  assign st_o.r0 = s0;
  assign st_o.kw = kw_next;

endmodule

FILE: src/shadow64_block_encrypt.sv
// Top level of the Shadow-64 block encryptor: a fully unrolled round pipeline.
// Depends on shd64_pkg and instantiates shd64_round once per round.
//
// This block encrypts one 64-bit block under a 128-bit key per input beat and
// returns one 64-bit ciphertext beat for each. Every round has its own pipeline
// stage, holding the data halves and the evolving key words, so a new block can
// be accepted on every clock cycle while the output is not stalled; throughput
// is then one block per cycle. An accepted input beat is loaded into the first
// round stage, moves on through the round stages in order and from the last
// of them into the output register, which also performs the final swap of the
// l0 and r0 halves. The pipeline holds up to ROUNDS + 1 beats in flight.
// Each stage carries its own valid bit and moves forward whenever the stage
// after it is empty or moving, so bubbles are squeezed out under output stall
// and the input keeps being accepted until every stage is full. No key or data
// is retained between blocks; every beat carries its own key. There are no
// configuration registers and no clearing pass after reset.
module shadow64_block_encrypt import shd64_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_plain_block,
  input  logic [63:0] in_key_low,
  input  logic [63:0] in_key_high,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cipher_block
);

  blk_state_t  stage_r   [ROUNDS];
  blk_state_t  stage_nxt [ROUNDS];
  blk_state_t  round_in  [ROUNDS];
  logic [ROUNDS-1:0] vld_r;
  logic [ROUNDS:0]   rdy;

  logic        out_valid_r;
  logic [63:0] out_cipher_block_r;
  logic [63:0] out_cipher_block_nxt;

  // Load side: unpack the plaintext halves and the four key words.
  always_comb begin
    round_in[0].l0    = in_plain_block[63:48];
    round_in[0].l1    = in_plain_block[47:32];
    round_in[0].r0    = in_plain_block[31:16];
    round_in[0].r1    = in_plain_block[15:0];
    round_in[0].kw[0] = in_key_low[31:0];
    round_in[0].kw[1] = in_key_low[63:32];
    round_in[0].kw[2] = in_key_high[31:0];
    round_in[0].kw[3] = in_key_high[63:32];
    for (int i = 1; i < ROUNDS; i++) begin
      round_in[i] = stage_r[i-1];
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy[ROUNDS] = !out_valid_r || !out_stall;
    for (int i = ROUNDS - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    shd64_round u_round (
      .st_i (round_in[g]),
      .st_o (stage_nxt[g])
    );
  end

  // Payload registers: no reset, loaded whenever the stage is ready.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ROUNDS; i++) begin
      if (rdy[i]) begin
        stage_r[i] <= stage_nxt[i];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < ROUNDS; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // The last round's output is stored with l0 and r0 swapped.
  assign out_cipher_block_nxt = {stage_r[ROUNDS-1].r0, stage_r[ROUNDS-1].l1,
                                 stage_r[ROUNDS-1].l0, stage_r[ROUNDS-1].r1};

  always_ff @(posedge clk) begin
    if (rdy[ROUNDS]) begin
      out_cipher_block_r <= out_cipher_block_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[ROUNDS]) begin
      out_valid_r <= vld_r[ROUNDS-1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_block = out_cipher_block_r;

endmodule

FILE: src/shd64_checker.sv
// Port-level checker for shadow64_block_encrypt, attached with a bind statement.
// Depends on nothing but the top level's port names.
module shd64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [63:0] in_plain_block,
  input logic [63:0] in_key_low,
  input logic [63:0] in_key_high,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_cipher_block
);

  // A stalled result beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cipher_block))
    else $error("stalled output beat changed or dropped");

  // A stalled input beat stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_plain_block) &&
      $stable(in_key_low) && $stable(in_key_high))
    else $error("stalled input beat changed or dropped");

  // If the output register is empty or draining, the pipeline accepts input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled while the output side is free");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // An input stall can only happen while a result waits behind a stall.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stall appeared without output back-pressure");

endmodule

bind shadow64_block_encrypt shd64_checker u_shd64_checker (.*);
